// ----- rtl/core/banked_flash_command_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Banked flash command unit: assertion macros
// Shared property shorthands for the concurrent checks of the unit.
// ---------------------------------------------------------------------------
`ifndef BANKED_FLASH_COMMAND_UNIT_DEFINES_SVH
`define BANKED_FLASH_COMMAND_UNIT_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define BFCU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define BFCU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bfcu_pkg.sv -----
// ---------------------------------------------------------------------------
// Banked flash command unit: shared package
// Bus codes, command sequencer codes, defaults and controller interface types.
// ---------------------------------------------------------------------------
`default_nettype none

package bfcu_pkg;

  // parameter defaults
  localparam int BANK_BYTES_DEF   = 65536;
  localparam int SECTOR_BYTES_DEF = 4096;
  localparam int NUM_BANKS_DEF    = 2;

  // bus item fields
  localparam int ADDR_W = 16;
  localparam int DATA_W = 8;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MANUFACTURER_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID       = 1'd1;

  localparam logic [DATA_W-1:0] MANUFACTURER_ID_RST = 8'h62;
  localparam logic [DATA_W-1:0] DEVICE_ID_RST       = 8'h13;

  // unlock addresses and command bytes
  localparam logic [ADDR_W-1:0] ADDR_UNLOCK_A = 16'h5555;
  localparam logic [ADDR_W-1:0] ADDR_UNLOCK_B = 16'h2AAA;
  localparam logic [ADDR_W-1:0] ADDR_ZERO     = 16'h0000;
  localparam logic [ADDR_W-1:0] ADDR_ONE      = 16'h0001;

  localparam logic [DATA_W-1:0] BYTE_UNLOCK_A   = 8'hAA;
  localparam logic [DATA_W-1:0] BYTE_UNLOCK_B   = 8'h55;
  localparam logic [DATA_W-1:0] BYTE_ID_MODE    = 8'h90;
  localparam logic [DATA_W-1:0] BYTE_ERASE      = 8'h80;
  localparam logic [DATA_W-1:0] BYTE_PROGRAM    = 8'hA0;
  localparam logic [DATA_W-1:0] BYTE_BANK_SEL   = 8'hB0;
  localparam logic [DATA_W-1:0] BYTE_RESET      = 8'hF0;
  localparam logic [DATA_W-1:0] BYTE_CHIP_ERASE = 8'h10;
  localparam logic [DATA_W-1:0] BYTE_SECT_ERASE = 8'h30;
  localparam logic [DATA_W-1:0] BYTE_ERASED     = 8'hFF;

  // command sequencer codes
  localparam int SEQ_W = 4;
  localparam logic [SEQ_W-1:0] SEQ_READY   = 4'd0;
  localparam logic [SEQ_W-1:0] SEQ_UNLOCK1 = 4'd1;
  localparam logic [SEQ_W-1:0] SEQ_UNLOCK2 = 4'd2;
  localparam logic [SEQ_W-1:0] SEQ_ID      = 4'd3;
  localparam logic [SEQ_W-1:0] SEQ_PROGRAM = 4'd4;
  localparam logic [SEQ_W-1:0] SEQ_ERASE1  = 4'd5;
  localparam logic [SEQ_W-1:0] SEQ_ERASE2  = 4'd6;
  localparam logic [SEQ_W-1:0] SEQ_ERASE3  = 4'd7;
  localparam logic [SEQ_W-1:0] SEQ_BANK    = 4'd8;

  // controller to datapath
  typedef struct packed {
    logic load_item;   // capture the bus item
    logic reduce;      // fold the address into the bank window
    logic seq_update;  // apply the write to the command sequencer
    logic mem_read;    // read the store at the item address
    logic mem_prog;    // program the store at the item address
    logic chip_load;   // set the sweep over the whole store
    logic sec_load;    // start the sector search
    logic sec_step;    // one sector search step
    logic sec_start;   // capture the sector start
    logic sec_base;    // set the sweep start and sector end
    logic sec_limit;   // set the sweep limit clipped to the bank
    logic sweep;       // erase one byte and advance
    logic out_load;    // load the result register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_write;
    logic id_mode;
    logic res_ok;
    logic sec_ok;
    logic act_program;
    logic act_chip;
    logic act_sector;
    logic sweep_done;
    logic out_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/bfcu_ram.sv -----
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module bfcu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bfcu_dp.sv -----
// ---------------------------------------------------------------------------
// Banked flash command unit: datapath
// Item registers, command sequencer, address folding, erase sweep, store
// and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module bfcu_dp
  import bfcu_pkg::*;
#(
  parameter int BANK_BYTES   = BANK_BYTES_DEF,
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
  parameter int NUM_BANKS    = NUM_BANKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd,
  input  logic [ADDR_W-1:0]    addr,
  input  logic [DATA_W-1:0]    data,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [DATA_W-1:0]    read_data,
  input  ctrl_cmd_t            ctl_cmd,
  output ctrl_status_t         st
);

  localparam int MEM_DEPTH = NUM_BANKS * BANK_BYTES;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int BANK_AW   = $clog2(BANK_BYTES);
  localparam int SZ_W      = ADDR_W + 1;

  localparam logic [SZ_W-1:0]   BANK_SZ    = SZ_W'(BANK_BYTES);
  localparam logic [SZ_W-1:0]   SECT_SZ    = SZ_W'(SECTOR_BYTES);
  localparam logic [MEM_AW-1:0] BANK_BASE1 = MEM_AW'(NUM_BANKS > 1 ? BANK_BYTES : 0);
  localparam logic [MEM_AW-1:0] MEM_LAST   = MEM_AW'(MEM_DEPTH - 1);

  // item and working registers
  logic                 item_cmd;
  logic [ADDR_W-1:0]    item_addr;
  logic [DATA_W-1:0]    item_data;
  logic [ADDR_W-1:0]    res;
  logic [BANK_AW-1:0]   sec_res;
  logic [BANK_AW-1:0]   sec_start;
  logic [SZ_W-1:0]      sec_end;
  logic [MEM_AW-1:0]    ptr;
  logic [MEM_AW-1:0]    last;

  // architectural state
  logic [SEQ_W-1:0]     seq_state;
  logic [SEQ_W-1:0]     seq_state_next;
  logic                 bank_sel;
  logic [DATA_W-1:0]    manufacturer_id;
  logic [DATA_W-1:0]    device_id;

  logic                 unlock_a;
  logic                 unlock_b;
  logic [BANK_AW-1:0]   off;
  logic [MEM_AW-1:0]    bank_base;
  logic [MEM_AW-1:0]    item_maddr;
  logic [SZ_W-1:0]      end_calc;
  logic [BANK_AW-1:0]   last_off;
  logic [DATA_W-1:0]    id_byte;
  logic                 wr_en;
  logic [MEM_AW-1:0]    wr_addr;
  logic [DATA_W-1:0]    wr_data;
  logic [DATA_W-1:0]    rd_data;

  assign unlock_a = (item_addr == ADDR_UNLOCK_A) && (item_data == BYTE_UNLOCK_A);
  assign unlock_b = (item_addr == ADDR_UNLOCK_B) && (item_data == BYTE_UNLOCK_B);

  assign off        = res[BANK_AW-1:0];
  assign bank_base  = bank_sel ? BANK_BASE1 : '0;
  assign item_maddr = bank_base + MEM_AW'(off);
  assign end_calc   = SZ_W'(sec_start) + SECT_SZ;
  assign last_off   = (sec_end > BANK_SZ) ? BANK_AW'(BANK_SZ - 1'b1)
                                          : BANK_AW'(sec_end - 1'b1);

  always_comb begin
    if (item_addr == ADDR_ZERO) begin
      id_byte = manufacturer_id;
    end else if (item_addr == ADDR_ONE) begin
      id_byte = device_id;
    end else begin
      id_byte = '0;
    end
  end

  // command sequencer next state for a write beat
  always_comb begin
    seq_state_next = SEQ_READY;
    unique case (seq_state)
      SEQ_UNLOCK1: seq_state_next = unlock_b ? SEQ_UNLOCK2 : SEQ_READY;
      SEQ_UNLOCK2: begin
        if (item_addr == ADDR_UNLOCK_A) begin
          unique case (item_data)
            BYTE_ID_MODE:  seq_state_next = SEQ_ID;
            BYTE_ERASE:    seq_state_next = SEQ_ERASE1;
            BYTE_PROGRAM:  seq_state_next = SEQ_PROGRAM;
            BYTE_BANK_SEL: seq_state_next = SEQ_BANK;
            default:       seq_state_next = SEQ_READY;
          endcase
        end
      end
      SEQ_ID:      seq_state_next = (item_data == BYTE_RESET) ? SEQ_READY : SEQ_ID;
      SEQ_ERASE1:  seq_state_next = unlock_a ? SEQ_ERASE2 : SEQ_READY;
      SEQ_ERASE2:  seq_state_next = unlock_b ? SEQ_ERASE3 : SEQ_READY;
      SEQ_PROGRAM, SEQ_ERASE3, SEQ_BANK: seq_state_next = SEQ_READY;
      default:     seq_state_next = unlock_a ? SEQ_UNLOCK1 : SEQ_READY;
    endcase
  end

  // status
  assign st.is_write    = (item_cmd == CMD_WRITE);
  assign st.id_mode     = (seq_state == SEQ_ID);
  assign st.res_ok      = ({1'b0, res} < BANK_SZ);
  assign st.sec_ok      = (SZ_W'(sec_res) < SECT_SZ);
  assign st.act_program = (seq_state == SEQ_PROGRAM);
  assign st.act_chip    = (seq_state == SEQ_ERASE3) && (item_addr == ADDR_UNLOCK_A) &&
                          (item_data == BYTE_CHIP_ERASE);
  assign st.act_sector  = (seq_state == SEQ_ERASE3) && !st.act_chip &&
                          (item_data == BYTE_SECT_ERASE);
  assign st.sweep_done  = (ptr == last);
  assign st.out_free    = !out_valid || out_ready;

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl_cmd.load_item) begin
      item_cmd  <= cmd;
      item_addr <= addr;
      item_data <= data;
      res       <= addr;
    end else if (ctl_cmd.reduce && !st.res_ok) begin
      res <= res - ADDR_W'(BANK_SZ);
    end

    if (ctl_cmd.sec_load) begin
      sec_res <= off;
    end else if (ctl_cmd.sec_step && !st.sec_ok) begin
      sec_res <= sec_res - BANK_AW'(SECT_SZ);
    end

    if (ctl_cmd.sec_start) begin
      sec_start <= off - sec_res;
    end
    if (ctl_cmd.sec_base) begin
      sec_end <= end_calc;
    end

    if (ctl_cmd.chip_load) begin
      ptr  <= '0;
      last <= MEM_LAST;
    end else if (ctl_cmd.sec_base) begin
      ptr <= bank_base + MEM_AW'(sec_start);
    end else if (ctl_cmd.sweep) begin
      ptr <= ptr + 1'b1;
    end
    if (ctl_cmd.sec_limit) begin
      last <= bank_base + MEM_AW'(last_off);
    end

    if (ctl_cmd.out_load) begin
      read_data <= st.id_mode ? id_byte : rd_data;
    end
  end

  // control and configuration state
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state       <= SEQ_READY;
      bank_sel        <= 1'b0;
      manufacturer_id <= MANUFACTURER_ID_RST;
      device_id       <= DEVICE_ID_RST;
      out_valid       <= 1'b0;
    end else begin
      if (ctl_cmd.seq_update) begin
        seq_state <= seq_state_next;
        if ((seq_state == SEQ_BANK) && (item_addr == ADDR_ZERO)) begin
          bank_sel <= item_data[0];
        end
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MANUFACTURER_ID: manufacturer_id <= cfg_data;
          CFG_DEVICE_ID:       device_id       <= cfg_data;
          default:             ;
        endcase
      end
      if (ctl_cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // store write port: program beat or erase sweep
  assign wr_en   = ctl_cmd.sweep || ctl_cmd.mem_prog;
  assign wr_addr = ctl_cmd.sweep ? ptr : item_maddr;
  assign wr_data = ctl_cmd.sweep ? BYTE_ERASED : item_data;

  bfcu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ctl_cmd.mem_read),
    .rd_addr (item_maddr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

// ----- rtl/core/bfcu_ctrl.sv -----
// ---------------------------------------------------------------------------
// Banked flash command unit: controller
// Sequences each bus beat through address folding, decode, store access,
// result hand-off and erase sweeps.
// ---------------------------------------------------------------------------
`default_nettype none

module bfcu_ctrl
  import bfcu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  ctrl_status_t st,
  output ctrl_cmd_t    ctl_cmd
);

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_SWEEP   = 4'd1;
  localparam logic [3:0] S_IDLE    = 4'd2;
  localparam logic [3:0] S_REDUCE  = 4'd3;
  localparam logic [3:0] S_DECIDE  = 4'd4;
  localparam logic [3:0] S_OUT     = 4'd5;
  localparam logic [3:0] S_SECFIND = 4'd6;
  localparam logic [3:0] S_SECSET  = 4'd7;
  localparam logic [3:0] S_SECLIM  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl_cmd    = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        ctl_cmd.chip_load = 1'b1;
        state_next        = S_SWEEP;
      end
      S_SWEEP: begin
        ctl_cmd.sweep = 1'b1;
        if (st.sweep_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl_cmd.load_item = 1'b1;
          state_next        = S_REDUCE;
        end
      end
      S_REDUCE: begin
        ctl_cmd.reduce = 1'b1;
        if (st.res_ok) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!st.is_write) begin
          ctl_cmd.mem_read = !st.id_mode;
          state_next       = S_OUT;
        end else begin
          ctl_cmd.seq_update = 1'b1;
          if (st.act_program) begin
            ctl_cmd.mem_prog = 1'b1;
            state_next       = S_IDLE;
          end else if (st.act_chip) begin
            ctl_cmd.chip_load = 1'b1;
            state_next        = S_SWEEP;
          end else if (st.act_sector) begin
            ctl_cmd.sec_load = 1'b1;
            state_next       = S_SECFIND;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_OUT: begin
        // hold the read data until the result register frees
        if (st.out_free) begin
          ctl_cmd.out_load = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_SECFIND: begin
        ctl_cmd.sec_step = 1'b1;
        if (st.sec_ok) begin
          ctl_cmd.sec_start = 1'b1;
          state_next        = S_SECSET;
        end
      end
      S_SECSET: begin
        ctl_cmd.sec_base = 1'b1;
        state_next       = S_SECLIM;
      end
      S_SECLIM: begin
        ctl_cmd.sec_limit = 1'b1;
        state_next        = S_SWEEP;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/banked_flash_command_unit.sv -----
// ---------------------------------------------------------------------------
// Banked flash command unit
// Byte-bus flash of NUM_BANKS banks taking unlock-prefixed command writes:
// ID mode, byte program, chip and sector erase, bank select and reset.
//
//   channel  signals                          beat
//   in       in_valid/in_ready                cmd, addr, data
//   out      out_valid/out_ready              read_data (one per read)
//   cfg      cfg_valid/cfg_ready (always 1)   cfg_index, cfg_data
//
// A read passes S_IDLE, S_REDUCE, S_DECIDE and S_OUT, a write the first
// three; S_REDUCE folds out one BANK_BYTES per step while the address lies
// beyond the bank window. Erases go through the store's single write port
// one byte a cycle: chip erase sweeps the whole store, sector erase up to
// SECTOR_BYTES bytes after up to BANK_BYTES/SECTOR_BYTES-1 search steps and
// the set-up states S_SECSET and S_SECLIM. After reset the store is cleared
// with in_ready low; configuration writes are taken throughout.
// A read result waits in the output register while the next beat is taken.
// ---------------------------------------------------------------------------
`default_nettype none

`include "banked_flash_command_unit_defines.svh"

module banked_flash_command_unit
  import bfcu_pkg::*;
#(
  parameter int BANK_BYTES   = BANK_BYTES_DEF,
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
  parameter int NUM_BANKS    = NUM_BANKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cmd,
  input  logic [ADDR_W-1:0]    addr,
  input  logic [DATA_W-1:0]    data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    read_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  ctrl_cmd_t    ctl_cmd;
  ctrl_status_t st;

  assign cfg_ready = 1'b1;

  bfcu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .ctl_cmd  (ctl_cmd)
  );

  bfcu_dp #(
    .BANK_BYTES   (BANK_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES),
    .NUM_BANKS    (NUM_BANKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .addr      (addr),
    .data      (data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .read_data (read_data),
    .ctl_cmd   (ctl_cmd),
    .st        (st)
  );

  `BFCU_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready,
                    "in_ready high after accepted beat")
  `BFCU_ASSERT_NEXT(a_read_to_result, clk, rst, ctl_cmd.mem_read,
                    ctl_cmd.out_load || !st.out_free,
                    "store read not handed to result register")
  `BFCU_ASSERT_SAME(a_clear_after_reset, clk, rst, $fell(rst), !in_ready,
                    "beat accepted before store clear")

endmodule

`default_nettype wire

// ----- test/tb_banked_flash_command_unit.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Banked flash command unit testbench
// Drives read and write beats through the bus with random gaps on both
// sides. A byte-level image of the flash and its command sequencer predicts
// each read. A short directed table covers ID mode, program, sector and chip
// erase and bank select. Four random phases follow, under different ID
// register settings: mostly well-formed command sequences, with broken
// sequences and noise mixed in.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_banked_flash_command_unit;
  import bfcu_pkg::*;

  localparam int FLASH_BYTES    = BANK_BYTES_DEF * NUM_BANKS_DEF;
  localparam int PHASE_ITEMS    = 275;
  // chip erase and the clearing pass after reset each sweep the whole store
  localparam int WATCHDOG_LIMIT = 600000;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] wdata;
    bit                checked;
    logic [DATA_W-1:0] rdata;
  } stim_row_t;

  localparam int N_DIRECTED = 32;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 cmd = CMD_READ;
  logic [ADDR_W-1:0]    addr = '0;
  logic [DATA_W-1:0]    data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DATA_W-1:0]    read_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  // predicted device state
  logic [DATA_W-1:0] flash_img [0:FLASH_BYTES-1];
  logic [SEQ_W-1:0]  seq_state;
  logic              bank_now;
  logic [DATA_W-1:0] mfr_now;
  logic [DATA_W-1:0] dev_now;

  logic [DATA_W-1:0] expected_bytes [$];
  logic [ADDR_W-1:0] hot_addr [16];
  int                errors = 0;
  int                items_sent = 0;
  int                sector_erases_left = 24;
  int                chip_erases_left = 1;
  int                stall_left = 0;
  int                idle_cycles = 0;
  logic              calm = 1'b0;
  logic [DATA_W-1:0] want_byte;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{CMD_READ,  ADDR_ZERO,     8'h00,           1'b1, BYTE_ERASED},
    '{CMD_WRITE, ADDR_UNLOCK_A, BYTE_UNLOCK_A,   1'b0, 8'h00},
    '{CMD_WRITE, ADDR_UNLOCK_B, BYTE_UNLOCK_B,   1'b0, 8'h00},
    '{CMD_WRITE, ADDR_UNLOCK_A, BYTE_ID_MODE,    1'b0, 8'h00},
    '{CMD_READ,  ADDR_ZERO,     8'hFF,           1'b1, MANUFACTURER_ID_RST},
    '{CMD_READ,  ADDR_ONE,      8'h00,           1'b1, DEVICE_ID_RST},
    '{CMD_READ,  16'hFFFF,      8'h00,           1'b1, 8'h00},
    '{CMD_WRITE, ADDR_ONE,      8'h55,           1'b0, 8'h00},
    '{CMD_WRITE, 16'hFFFF,      BYTE_RESET,      1'b0, 8'h00},
    '{CMD_WRITE, ADDR_UNLOCK_A, BYTE_UNLOCK_A,   1'b0, 8'h00},
    '{CMD_WRITE, ADDR_UNLOCK_B, BYTE_UNLOCK_B,   1'b0, 8'h00},
    '{CMD_WRITE, ADDR_UNLOCK_A, BYTE_PROGRAM,    1'b0, 8'h00},
    '{CMD_WRITE, 16'hFFFF,      8'h00,           1'b0, 8'h00},
    '{CMD_READ,  16'hFFFF,      8'h00,           1'b1, 8'h00},
    '{CMD_WRITE, ADDR_UNLOCK_A, BYTE_UNLOCK_A,   1'b0, 8'h00},
    '{CMD_WRITE, ADDR_UNLOCK_B, BYTE_UNLOCK_B,   1'b0, 8'h00},
    '{CMD_WRITE, ADDR_UNLOCK_A, BYTE_ERASE,      1'b0, 8'h00},
    '{CMD_WRITE, ADDR_UNLOCK_A, BYTE_UNLOCK_A,   1'b0, 8'h00},
    '{CMD_WRITE, ADDR_UNLOCK_B, BYTE_UNLOCK_B,   1'b0, 8'h00},
    '{CMD_WRITE, 16'hF123,      BYTE_SECT_ERASE, 1'b0, 8'h00},
    '{CMD_READ,  16'hFFFF,      8'h00,           1'b1, BYTE_ERASED},
    '{CMD_WRITE, ADDR_UNLOCK_A, BYTE_UNLOCK_A,   1'b0, 8'h00},
    '{CMD_WRITE, ADDR_UNLOCK_B, BYTE_UNLOCK_B,   1'b0, 8'h00},
    '{CMD_WRITE, ADDR_UNLOCK_A, BYTE_BANK_SEL,   1'b0, 8'h00},
    '{CMD_WRITE, ADDR_ZERO,     8'hFF,           1'b0, 8'h00},
    '{CMD_WRITE, ADDR_UNLOCK_A, BYTE_UNLOCK_A,   1'b0, 8'h00},
    '{CMD_WRITE, ADDR_UNLOCK_B, BYTE_UNLOCK_B,   1'b0, 8'h00},
    '{CMD_WRITE, ADDR_UNLOCK_A, BYTE_ERASE,      1'b0, 8'h00},
    '{CMD_WRITE, ADDR_UNLOCK_A, BYTE_UNLOCK_A,   1'b0, 8'h00},
    '{CMD_WRITE, ADDR_UNLOCK_B, BYTE_UNLOCK_B,   1'b0, 8'h00},
    '{CMD_WRITE, ADDR_UNLOCK_A, BYTE_CHIP_ERASE, 1'b0, 8'h00},
    '{CMD_READ,  ADDR_ZERO,     8'h00,           1'b1, BYTE_ERASED}
  };

  banked_flash_command_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .addr      (addr),
    .data      (data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void fill_flash();
    for (int i = 0; i < FLASH_BYTES; i++) flash_img[i] = BYTE_ERASED;
  endfunction

  // apply one beat to the predicted state; returns 1 when a read byte results
  function automatic bit flash_beat(input logic kind, input logic [ADDR_W-1:0] a,
                                    input logic [DATA_W-1:0] d,
                                    output logic [DATA_W-1:0] byte_out);
    int base;
    int offs;
    int start;
    int len;
    bit ua;
    bit ub;
    base = (int'(bank_now) % NUM_BANKS_DEF) * BANK_BYTES_DEF;
    offs = int'(a) % BANK_BYTES_DEF;
    ua = (a == ADDR_UNLOCK_A) && (d == BYTE_UNLOCK_A);
    ub = (a == ADDR_UNLOCK_B) && (d == BYTE_UNLOCK_B);
    byte_out = '0;
    if (kind == CMD_READ) begin
      if (seq_state == SEQ_ID) begin
        if (a == ADDR_ZERO) byte_out = mfr_now;
        else if (a == ADDR_ONE) byte_out = dev_now;
      end else begin
        byte_out = flash_img[base + offs];
      end
      return 1'b1;
    end
    case (seq_state)
      SEQ_UNLOCK1: seq_state = ub ? SEQ_UNLOCK2 : SEQ_READY;
      SEQ_UNLOCK2: begin
        seq_state = SEQ_READY;
        if (a == ADDR_UNLOCK_A) begin
          if (d == BYTE_ID_MODE) seq_state = SEQ_ID;
          else if (d == BYTE_ERASE) seq_state = SEQ_ERASE1;
          else if (d == BYTE_PROGRAM) seq_state = SEQ_PROGRAM;
          else if (d == BYTE_BANK_SEL) seq_state = SEQ_BANK;
        end
      end
      SEQ_ID: if (d == BYTE_RESET) seq_state = SEQ_READY;
      SEQ_PROGRAM: begin
        flash_img[base + offs] = d;
        seq_state = SEQ_READY;
      end
      SEQ_ERASE1: seq_state = ua ? SEQ_ERASE2 : SEQ_READY;
      SEQ_ERASE2: seq_state = ub ? SEQ_ERASE3 : SEQ_READY;
      SEQ_ERASE3: begin
        if (a == ADDR_UNLOCK_A && d == BYTE_CHIP_ERASE) begin
          fill_flash();
        end else if (d == BYTE_SECT_ERASE) begin
          start = (offs / SECTOR_BYTES_DEF) * SECTOR_BYTES_DEF;
          if (start < BANK_BYTES_DEF) begin
            len = SECTOR_BYTES_DEF;
            if (len > BANK_BYTES_DEF - start) len = BANK_BYTES_DEF - start;
            for (int i = 0; i < len; i++) flash_img[base + start + i] = BYTE_ERASED;
          end
        end
        seq_state = SEQ_READY;
      end
      SEQ_BANK: begin
        if (a == ADDR_ZERO) bank_now = d[0];
        seq_state = SEQ_READY;
      end
      default: seq_state = ua ? SEQ_UNLOCK1 : SEQ_READY;
    endcase
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 9) < 6) return hot_addr[$urandom_range(0, 15)];
    return ADDR_W'($urandom);
  endfunction

  function automatic logic [DATA_W-1:0] pick_command();
    case ($urandom_range(0, 5))
      0: return BYTE_ID_MODE;
      1: return BYTE_ERASE;
      2: return BYTE_PROGRAM;
      3: return BYTE_BANK_SEL;
      4: return BYTE_RESET;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // hold valid across back-to-back beats; drop it only for a gap
  task automatic send_item(input logic kind, input logic [ADDR_W-1:0] a,
                           input logic [DATA_W-1:0] d, input bit fixed = 1'b0,
                           input logic [DATA_W-1:0] fixed_byte = '0);
    int gap;
    logic [DATA_W-1:0] byte_out;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= kind;
    addr     <= a;
    data     <= d;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (flash_beat(kind, a, d, byte_out))
      expected_bytes.push_back(fixed ? fixed_byte : byte_out);
  endtask

  task automatic write_beat(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    send_item(CMD_WRITE, a, d);
  endtask

  task automatic read_beat(input logic [ADDR_W-1:0] a);
    send_item(CMD_READ, a, DATA_W'($urandom));
  endtask

  task automatic unlock_pair();
    write_beat(ADDR_UNLOCK_A, BYTE_UNLOCK_A);
    write_beat(ADDR_UNLOCK_B, BYTE_UNLOCK_B);
  endtask

  // end on a read so that its return proves every earlier beat has finished
  task automatic drain_to_idle();
    read_beat(pick_addr());
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_ids(input logic [DATA_W-1:0] mfr, input logic [DATA_W-1:0] dev);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MANUFACTURER_ID;
    cfg_data  <= mfr;
    do @(posedge clk); while (!cfg_ready);
    mfr_now = mfr;
    cfg_index <= CFG_DEVICE_ID;
    cfg_data  <= dev;
    do @(posedge clk); while (!cfg_ready);
    dev_now = dev;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic erase_sequence();
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    unlock_pair();
    write_beat(ADDR_UNLOCK_A, BYTE_ERASE);
    unlock_pair();
    if (chip_erases_left > 0 && $urandom_range(0, 19) == 0) begin
      chip_erases_left--;
      write_beat(ADDR_UNLOCK_A, BYTE_CHIP_ERASE);
    end else if (sector_erases_left > 0 && $urandom_range(0, 2) != 0) begin
      sector_erases_left--;
      write_beat(pick_addr(), BYTE_SECT_ERASE);
    end else begin
      // third step that must do nothing
      a = ADDR_W'($urandom);
      d = ($urandom_range(0, 1) == 0) ? BYTE_CHIP_ERASE : DATA_W'($urandom);
      if (a == ADDR_UNLOCK_A) a[0] = ~a[0];
      if (d == BYTE_SECT_ERASE) d[0] = ~d[0];
      write_beat(a, d);
    end
    if ($urandom_range(0, 1) == 0) read_beat(pick_addr());
  endtask

  task automatic random_sequence();
    int r;
    logic [ADDR_W-1:0] a;
    r = $urandom_range(0, 99);
    if (r < 28) begin
      repeat ($urandom_range(1, 3)) read_beat(pick_addr());
    end else if (r < 50) begin
      unlock_pair();
      write_beat(ADDR_UNLOCK_A, BYTE_PROGRAM);
      a = pick_addr();
      write_beat(a, DATA_W'($urandom));
      if ($urandom_range(0, 9) < 7) read_beat(a);
    end else if (r < 60) begin
      unlock_pair();
      write_beat(ADDR_UNLOCK_A, BYTE_ID_MODE);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 3))
          0: read_beat(ADDR_ZERO);
          1: read_beat(ADDR_ONE);
          2: read_beat(pick_addr());
          default: write_beat(pick_addr(), DATA_W'($urandom));
        endcase
      end
      write_beat(ADDR_W'($urandom), BYTE_RESET);
    end else if (r < 67) begin
      unlock_pair();
      write_beat(ADDR_UNLOCK_A, BYTE_BANK_SEL);
      a = ($urandom_range(0, 3) != 0) ? ADDR_ZERO : ADDR_W'($urandom);
      write_beat(a, DATA_W'($urandom));
    end else if (r < 75) begin
      erase_sequence();
    end else if (r < 80) begin
      unlock_pair();
      write_beat(ADDR_UNLOCK_A, DATA_W'($urandom));
    end else if (r < 90) begin
      case ($urandom_range(0, 3))
        0: write_beat(ADDR_UNLOCK_A, BYTE_UNLOCK_A);
        1: begin
          unlock_pair();
          a = ADDR_W'($urandom);
          if (a == ADDR_UNLOCK_A) a[0] = ~a[0];
          write_beat(a, pick_command());
        end
        2: begin
          unlock_pair();
          write_beat(ADDR_UNLOCK_A, BYTE_ERASE);
          if ($urandom_range(0, 1) == 0) write_beat(ADDR_UNLOCK_A, BYTE_UNLOCK_A);
        end
        default: write_beat(ADDR_UNLOCK_B, BYTE_UNLOCK_B);
      endcase
      write_beat(ADDR_W'($urandom), DATA_W'($urandom));
      read_beat(pick_addr());
    end else begin
      repeat ($urandom_range(1, 4))
        send_item(logic'($urandom_range(0, 1)), ADDR_W'($urandom), DATA_W'($urandom));
    end
  endtask

  task automatic random_phase(input int n_items);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) random_sequence();
    drain_to_idle();
  endtask

  // read results: check in order, stall at random
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $error("read_data beat with no read pending: got %02h", read_data);
        errors++;
      end else begin
        want_byte = expected_bytes.pop_front();
        if (read_data !== want_byte) begin
          $error("read_data mismatch: expected %02h, got %02h", want_byte, read_data);
          errors++;
        end
      end
    end
    if ($urandom_range(0, 299) == 0) calm <= ~calm;
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    hot_addr[0] = ADDR_ZERO;
    hot_addr[1] = ADDR_ONE;
    hot_addr[2] = ADDR_UNLOCK_A;
    hot_addr[3] = ADDR_UNLOCK_B;
    hot_addr[4] = 16'hFFFF;
    for (int i = 5; i < 16; i++) hot_addr[i] = ADDR_W'($urandom);
    fill_flash();
    seq_state = SEQ_READY;
    bank_now  = 1'b0;
    mfr_now   = MANUFACTURER_ID_RST;
    dev_now   = DEVICE_ID_RST;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].kind, directed_rows[i].address, directed_rows[i].wdata,
                directed_rows[i].checked, directed_rows[i].rdata);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    write_ids(8'h00, 8'hFF);
    random_phase(PHASE_ITEMS);
    write_ids(8'hFF, 8'h00);
    random_phase(PHASE_ITEMS);
    write_ids(DATA_W'($urandom), DATA_W'($urandom));
    random_phase(PHASE_ITEMS);
    write_ids(DATA_W'($urandom), DATA_W'($urandom));
    random_phase(PHASE_ITEMS);

    repeat (20) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
